/* hw/rtl/ffa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types and codes of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FRAG  = 8'd1;

  localparam int SIZE_W  = 19;
  localparam int ADDR_W  = 32;
  localparam int COUNT_W = 13;
  localparam int NEED_W  = 20;

  localparam int BLOCK_BYTES = 64;
  localparam int BLOCK_SH    = $clog2(BLOCK_BYTES);

  typedef struct packed {
    logic              action;
    logic [SIZE_W-1:0] size_bytes;
    logic [ADDR_W-1:0] address;
  } in_word_t;

  typedef struct packed {
    logic               status;
    logic [ADDR_W-1:0]  result_address;
    logic [COUNT_W-1:0] free_blocks;
    logic [COUNT_W-1:0] taken_blocks;
  } out_word_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DIV, S_ANEED, S_AWALK, S_AWAIT, S_ATAKE, S_AFIX1, S_AFIX2,
    S_FCHK, S_FLIVE, S_FWALK, S_FWAIT, S_FAFT, S_FLINK, S_FLINK2, S_DONE
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLEAR, OP_LOAD, OP_DIV, OP_ANEED, OP_AREAD, OP_AFAIL, OP_AWAIT,
    OP_ATAKE, OP_AFIX1, OP_AFIX2, OP_FCHK, OP_FLIVE, OP_FREAD, OP_FWAIT, OP_FAFT,
    OP_FLINK, OP_FLINK2, OP_OUT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic div_done;
    logic is_free;
    logic cur_none;
    logic fit;
    logic chk_bad;
    logic live_bit;
    logic walk_more;
    logic after_none;
    logic out_busy;
  } sts_t;

endpackage

/* hw/rtl/ffa_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_div
// Split of a byte offset into block index and byte remainder by shift and mask.
// ----------------------------------------------------------------------------
module ffa_div import ffa_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [31:0]         dividend,
  output logic [31:0]         quotient,
  output logic [BLOCK_SH-1:0] remainder,
  output logic                done
);

  logic [31:0]         quo_r;
  logic [BLOCK_SH-1:0] rem_r;
  logic                done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend >> BLOCK_SH;
      rem_r <= dividend[BLOCK_SH-1:0];
    end
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign done      = done_r;

endmodule

/* hw/rtl/ffa_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_ctrl
// Sequencer for clearing, allocate walk and free insert/merge.
// ----------------------------------------------------------------------------
module ffa_ctrl import ffa_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR:  if (sts.clr_done) state_nxt = S_IDLE;
      S_IDLE:   if (in_valid) state_nxt = S_DIV;
      S_DIV:    if (sts.div_done) state_nxt = sts.is_free ? S_FCHK : S_ANEED;
      S_ANEED:  state_nxt = S_AWALK;
      S_AWALK:  state_nxt = sts.cur_none ? S_DONE : S_AWAIT;
      S_AWAIT:  state_nxt = sts.fit ? S_ATAKE : S_AWALK;
      S_ATAKE:  state_nxt = S_AFIX1;
      S_AFIX1:  state_nxt = S_AFIX2;
      S_AFIX2:  state_nxt = S_DONE;
      S_FCHK:   state_nxt = sts.chk_bad ? S_DONE : S_FLIVE;
      S_FLIVE:  state_nxt = sts.live_bit ? S_FWALK : S_DONE;
      S_FWALK: begin
        if (sts.walk_more) state_nxt = S_FWAIT;
        else if (sts.after_none) state_nxt = S_FLINK;
        else state_nxt = S_FAFT;
      end
      S_FWAIT:  state_nxt = S_FWALK;
      S_FAFT:   state_nxt = S_FLINK;
      S_FLINK:  state_nxt = S_FLINK2;
      S_FLINK2: state_nxt = S_DONE;
      S_DONE:   if (!sts.out_busy) state_nxt = S_IDLE;
      default:  state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd.op = OP_NONE;
    case (state_r)
      S_CLEAR:  cmd.op = OP_CLEAR;
      S_IDLE:   if (in_valid) cmd.op = OP_LOAD;
      S_DIV:    cmd.op = OP_DIV;
      S_ANEED:  cmd.op = OP_ANEED;
      S_AWALK:  cmd.op = sts.cur_none ? OP_AFAIL : OP_AREAD;
      S_AWAIT:  cmd.op = OP_AWAIT;
      S_ATAKE:  cmd.op = OP_ATAKE;
      S_AFIX1:  cmd.op = OP_AFIX1;
      S_AFIX2:  cmd.op = OP_AFIX2;
      S_FCHK:   cmd.op = OP_FCHK;
      S_FLIVE:  cmd.op = OP_FLIVE;
      S_FWALK:  cmd.op = sts.after_none ? OP_NONE : OP_FREAD;
      S_FWAIT:  cmd.op = OP_FWAIT;
      S_FAFT:   cmd.op = OP_FAFT;
      S_FLINK:  cmd.op = OP_FLINK;
      S_FLINK2: cmd.op = OP_FLINK2;
      S_DONE:   if (!sts.out_busy) cmd.op = OP_OUT;
      default:  cmd.op = OP_NONE;
    endcase
  end

  assign in_stall = state_r != S_IDLE;

endmodule

/* hw/rtl/ffa_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_dp
// Segment memories, live bits, counters, divider and result register.
// ----------------------------------------------------------------------------
module ffa_dp import ffa_pkg::*; #(
  parameter int HEAP_BLOCKS  = 4096,
  parameter int HEADER_BYTES = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  input  in_word_t             in_data,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_data
);

  localparam int IDX_W  = $clog2(HEAP_BLOCKS);
  localparam int LINK_W = $clog2(HEAP_BLOCKS + 1);
  localparam int RW     = BLOCK_SH;
  localparam logic [LINK_W-1:0] NONE = LINK_W'(HEAP_BLOCKS);

  logic [LINK_W-1:0] len_mem  [HEAP_BLOCKS];
  logic [LINK_W-1:0] next_mem [HEAP_BLOCKS];
  logic              live_mem [HEAP_BLOCKS];

  logic [31:0]        base_r;
  logic [COUNT_W-1:0] frag_r;
  logic [IDX_W-1:0]   clr_cnt_r;
  logic               act_r;
  logic [ADDR_W-1:0]  addr_r;
  logic [NEED_W-1:0]  need_r;
  logic [LINK_W-1:0]  head_r, cur_r, prev_r, follow_r, len_r, after_r;
  logic [LINK_W-1:0]  prev_len_r, blk_len_r, after_len_r, after_next_r;
  logic [IDX_W-1:0]   blk_r;
  logic               split_r;
  logic [31:0]        mul_r;
  logic [LINK_W-1:0]  free_cnt_r, taken_cnt_r;
  logic               res_status_r;
  logic [31:0]        res_addr_r;
  logic               out_valid_r;
  out_word_t          out_data_r;

  logic [IDX_W-1:0]   rd_addr;
  logic [LINK_W-1:0]  rd_len_r, rd_next_r;
  logic               live_rd_r;

  logic               len_we, next_we, live_we;
  logic [IDX_W-1:0]   len_wa, next_wa, live_wa;
  logic [LINK_W-1:0]  len_wd, next_wd;
  logic               live_wd;

  logic               div_start;
  logic [31:0]        div_dividend, div_quo;
  logic [RW-1:0]      div_rem;
  logic               div_done;

  logic [COUNT_W-1:0] frag_eff;
  logic [LINK_W-1:0]  rem_len, tail;
  logic               split;
  logic               prev_ok, mp, ma;
  logic [LINK_W:0]    prev_end, cur_end;
  logic [LINK_W-1:0]  cur_f, cur_len, fin_len, fin_next, blk_ext;

  ffa_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .quotient  (div_quo),
    .remainder (div_rem),
    .done      (div_done)
  );

  assign div_start    = cmd.op == OP_LOAD;
  assign div_dividend = in_data.action ?
                        in_data.address - base_r - 32'(HEADER_BYTES) :
                        32'(in_data.size_bytes) + 32'(BLOCK_BYTES - 1);

  assign frag_eff = (frag_r == '0) ? COUNT_W'(1) : frag_r;
  assign rem_len  = len_r - LINK_W'(need_r);
  assign split    = NEED_W'(rem_len) >= NEED_W'(frag_eff);
  assign tail     = cur_r + LINK_W'(need_r);

  assign blk_ext  = LINK_W'(blk_r);
  assign prev_ok  = prev_r != NONE;
  assign prev_end = (LINK_W+1)'(prev_r) + (LINK_W+1)'(prev_len_r);
  assign mp       = prev_ok && (prev_end == (LINK_W+1)'(blk_ext));
  assign cur_f    = mp ? prev_r : blk_ext;
  assign cur_len  = mp ? prev_len_r + blk_len_r : blk_len_r;
  assign cur_end  = (LINK_W+1)'(cur_f) + (LINK_W+1)'(cur_len);
  assign ma       = (after_r != NONE) && (cur_end == (LINK_W+1)'(after_r));
  assign fin_len  = ma ? cur_len + after_len_r : cur_len;
  assign fin_next = ma ? after_next_r : after_r;

  always_comb begin
    case (cmd.op)
      OP_FCHK: rd_addr = div_quo[IDX_W-1:0];
      OP_FREAD: rd_addr = after_r[IDX_W-1:0];
      default: rd_addr = cur_r[IDX_W-1:0];
    endcase
  end

  always_comb begin
    len_we  = 1'b0;
    len_wa  = cur_r[IDX_W-1:0];
    len_wd  = '0;
    next_we = 1'b0;
    next_wa = cur_r[IDX_W-1:0];
    next_wd = '0;
    live_we = 1'b0;
    live_wa = cur_r[IDX_W-1:0];
    live_wd = 1'b0;
    case (cmd.op)
      OP_CLEAR: begin
        live_we = 1'b1;
        live_wa = clr_cnt_r;
        len_we  = clr_cnt_r == '0;
        len_wa  = '0;
        len_wd  = LINK_W'(HEAP_BLOCKS);
        next_we = clr_cnt_r == '0;
        next_wa = '0;
        next_wd = NONE;
      end
      OP_ATAKE: begin
        len_we  = split;
        len_wa  = tail[IDX_W-1:0];
        len_wd  = rem_len;
        next_we = split;
        next_wa = tail[IDX_W-1:0];
        next_wd = follow_r;
      end
      OP_AFIX1: begin
        len_we  = split_r;
        len_wd  = LINK_W'(need_r);
        next_we = prev_ok;
        next_wa = prev_r[IDX_W-1:0];
        next_wd = follow_r;
      end
      OP_AFIX2: begin
        next_we = 1'b1;
        next_wd = NONE;
        live_we = 1'b1;
        live_wd = 1'b1;
      end
      OP_FLIVE: begin
        live_we = live_rd_r;
        live_wa = blk_r;
      end
      OP_FLINK: begin
        len_we  = 1'b1;
        len_wa  = cur_f[IDX_W-1:0];
        len_wd  = fin_len;
        next_we = 1'b1;
        next_wa = cur_f[IDX_W-1:0];
        next_wd = fin_next;
      end
      OP_FLINK2: begin
        next_we = !mp && prev_ok;
        next_wa = prev_r[IDX_W-1:0];
        next_wd = blk_ext;
      end
      default: begin
        len_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (len_we) len_mem[len_wa] <= len_wd;
    if (next_we) next_mem[next_wa] <= next_wd;
    if (live_we) live_mem[live_wa] <= live_wd;
    rd_len_r  <= len_mem[rd_addr];
    rd_next_r <= next_mem[rd_addr];
    live_rd_r <= live_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      frag_r      <= COUNT_W'(2);
      clr_cnt_r   <= '0;
      head_r      <= '0;
      free_cnt_r  <= LINK_W'(HEAP_BLOCKS);
      taken_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_HEAP_BASE: base_r <= cfg_data;
          CFG_MIN_FRAG:  frag_r <= cfg_data[COUNT_W-1:0];
          default:       base_r <= base_r;
        endcase
      end
      if (cmd.op == OP_OUT) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        OP_CLEAR: clr_cnt_r <= clr_cnt_r + IDX_W'(1);
        OP_AFIX1: if (!prev_ok) head_r <= follow_r;
        OP_AFIX2: begin
          free_cnt_r  <= free_cnt_r - len_r;
          taken_cnt_r <= taken_cnt_r + len_r;
        end
        OP_FLIVE: begin
          if (live_rd_r) begin
            free_cnt_r  <= free_cnt_r + rd_len_r;
            taken_cnt_r <= taken_cnt_r - rd_len_r;
          end
        end
        OP_FLINK2: if (!mp && !prev_ok) head_r <= blk_ext;
        default: clr_cnt_r <= clr_cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        act_r        <= in_data.action;
        addr_r       <= in_data.address;
        res_status_r <= 1'b0;
        res_addr_r   <= '0;
      end
      OP_ANEED: begin
        need_r <= NEED_W'(div_quo) +
                  NEED_W'((32'(BLOCK_BYTES - 1) - 32'(div_rem)) < 32'(HEADER_BYTES));
        cur_r  <= head_r;
        prev_r <= NONE;
      end
      OP_AFAIL: res_status_r <= 1'b1;
      OP_AWAIT: begin
        if (NEED_W'(rd_len_r) >= need_r) begin
          len_r    <= rd_len_r;
          follow_r <= rd_next_r;
        end else begin
          prev_r <= cur_r;
          cur_r  <= rd_next_r;
        end
      end
      OP_ATAKE: begin
        split_r <= split;
        if (split) begin
          follow_r <= tail;
          len_r    <= LINK_W'(need_r);
        end
      end
      OP_AFIX1: mul_r <= 32'(cur_r) * 32'(BLOCK_BYTES);
      OP_AFIX2: res_addr_r <= base_r + mul_r + 32'(HEADER_BYTES);
      OP_FCHK: blk_r <= div_quo[IDX_W-1:0];
      OP_FLIVE: begin
        blk_len_r <= rd_len_r;
        after_r   <= head_r;
        prev_r    <= NONE;
      end
      OP_FWAIT: begin
        prev_r     <= after_r;
        prev_len_r <= rd_len_r;
        after_r    <= rd_next_r;
      end
      OP_FAFT: begin
        after_len_r  <= rd_len_r;
        after_next_r <= rd_next_r;
      end
      OP_OUT: begin
        out_data_r.status         <= res_status_r;
        out_data_r.result_address <= res_addr_r;
        out_data_r.free_blocks    <= COUNT_W'(free_cnt_r);
        out_data_r.taken_blocks   <= COUNT_W'(taken_cnt_r);
      end
      default: mul_r <= mul_r;
    endcase
  end

  assign sts.clr_done   = clr_cnt_r == IDX_W'(HEAP_BLOCKS - 1);
  assign sts.div_done   = div_done;
  assign sts.is_free    = act_r;
  assign sts.cur_none   = cur_r == NONE;
  assign sts.fit        = NEED_W'(rd_len_r) >= need_r;
  assign sts.chk_bad    = (addr_r == '0) || (div_rem != '0) ||
                          (div_quo >= 32'(HEAP_BLOCKS));
  assign sts.live_bit   = live_rd_r;
  assign sts.walk_more  = (after_r != NONE) && (after_r < blk_ext);
  assign sts.after_none = after_r == NONE;
  assign sts.out_busy   = out_valid_r && out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* hw/rtl/first_fit_block_allocator_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_block_allocator_top
// First-fit heap allocator over an address-ordered, coalescing free list.
// Run time grows with each segment visited on allocate and with each segment
// below the freed block on free, plus any output stall; one word in flight,
// the next taken only once the result has loaded into the output register.
// After reset a clearing pass over all blocks runs before any word is taken;
// configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_top import ffa_pkg::*; #(
  parameter int HEAP_BLOCKS  = 4096,
  parameter int HEADER_BYTES = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  ffa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ffa_dp #(
    .HEAP_BLOCKS  (HEAP_BLOCKS),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  a_count_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (COUNT_W'(out_data.free_blocks + out_data.taken_blocks) ==
                   COUNT_W'(HEAP_BLOCKS)))
    else $error("free and taken counts do not cover the heap");

  a_fail_null: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status) |-> (out_data.result_address == '0))
    else $error("failed allocation returned an address");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again while a word is in progress");
`endif

endmodule
